// ----- hdl/pps_pkg.sv -----
package pps_pkg;

  // Fixed widths of the request and result fields.
  localparam int OP_W      = 2;
  localparam int SLOT_IN_W = 3;
  localparam int IN_TIME_W = 16;
  localparam int PRIO_W    = 8;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OP_W-1:0] OP_TICK  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic load;
    logic clear;
    logic scan;
    logic fetch;
    logic run;
    logic finish;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_last;
  } ctl_status_t;

endpackage

// ----- hdl/pps_ctrl.sv -----
module pps_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [pps_pkg::OP_W-1:0]     operation,
  input  pps_pkg::ctl_status_t         status,
  output pps_pkg::ctl_cmd_t            cmd,
  output logic                         busy,
  output logic                         done
);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_LOAD   = 9'b000000010,
    S_CLEAR  = 9'b000000100,
    S_SCAN   = 9'b000001000,
    S_SETTLE = 9'b000010000,
    S_FETCH  = 9'b000100000,
    S_RUN    = 9'b001000000,
    S_FINISH = 9'b010000000,
    S_REPORT = 9'b100000000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          if (operation == pps_pkg::OP_LOAD) begin
            state_next = S_LOAD;
          end else if (operation == pps_pkg::OP_TICK) begin
            state_next = S_SCAN;
          end else if (operation == pps_pkg::OP_CLEAR) begin
            state_next = S_CLEAR;
          end else begin
            state_next = S_REPORT;
          end
        end
      end
      S_LOAD:   state_next = S_REPORT;
      S_CLEAR:  state_next = S_REPORT;
      S_SCAN: begin
        if (status.scan_last) begin
          state_next = S_SETTLE;
        end
      end
      S_SETTLE: state_next = S_FETCH;
      S_FETCH:  state_next = S_RUN;
      S_RUN:    state_next = S_FINISH;
      S_FINISH: state_next = S_REPORT;
      S_REPORT: state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd.capture = (state == S_IDLE) && start;
    cmd.load    = (state == S_LOAD);
    cmd.clear   = (state == S_CLEAR);
    cmd.scan    = (state == S_SCAN);
    cmd.fetch   = (state == S_FETCH);
    cmd.run     = (state == S_RUN);
    cmd.finish  = (state == S_FINISH);
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_REPORT);

endmodule

// ----- hdl/pps_datapath.sv -----
module pps_datapath #(
  parameter int SLOTS     = 8,
  parameter int TIME_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  pps_pkg::ctl_cmd_t                 cmd,
  output pps_pkg::ctl_status_t              status,
  input  logic [pps_pkg::SLOT_IN_W-1:0]     slot,
  input  logic [pps_pkg::IN_TIME_W-1:0]     arrival,
  input  logic [pps_pkg::IN_TIME_W-1:0]     burst,
  input  logic [pps_pkg::PRIO_W-1:0]        priority_req,
  output logic                              ran,
  output logic [pps_pkg::SLOT_IN_W-1:0]     ran_slot,
  output logic                              completed,
  output logic [TIME_BITS-1:0]              completion_time,
  output logic [TIME_BITS-1:0]              turnaround,
  output logic [TIME_BITS-1:0]              waiting,
  output logic                              all_done,
  output logic [TIME_BITS-1:0]              time_now
);

  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int SIW    = pps_pkg::SLOT_IN_W;
  localparam int PW     = pps_pkg::PRIO_W;
  localparam logic [SLOT_W-1:0]    LAST_IDX = SLOT_W'(SLOTS - 1);
  localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

  // Captured request.
  logic [SIW-1:0]       slot_q;
  logic [TIME_BITS-1:0] arr_q;
  logic [TIME_BITS-1:0] burst_q;
  logic [PW-1:0]        prio_q;

  // Task table.
  logic [TIME_BITS-1:0] arr_mem   [SLOTS];
  logic [TIME_BITS-1:0] burst_mem [SLOTS];
  logic [TIME_BITS-1:0] rem_mem   [SLOTS];
  logic [PW-1:0]        prio_mem  [SLOTS];
  logic [SLOTS-1:0]     loaded;
  logic [SLOTS-1:0]     finished;
  logic [TIME_BITS-1:0] time_cnt;

  // Read port and scan bookkeeping.
  logic [SLOT_W-1:0]    rd_addr;
  logic [TIME_BITS-1:0] arr_rd;
  logic [TIME_BITS-1:0] burst_rd;
  logic [TIME_BITS-1:0] rem_rd;
  logic [PW-1:0]        prio_rd;
  logic [SLOT_W-1:0]    scan_idx;
  logic [SLOT_W-1:0]    idx_q;
  logic                 rd_valid;

  // Best candidate so far.
  logic                 found;
  logic [SLOT_W-1:0]    best_slot;
  logic [PW-1:0]        best_prio;
  logic [TIME_BITS-1:0] best_arr;

  // Result registers.
  logic                 ran_r;
  logic                 completed_r;
  logic [TIME_BITS-1:0] ctime_r;
  logic [TIME_BITS-1:0] tat_r;
  logic [TIME_BITS-1:0] burst_r;
  logic [TIME_BITS-1:0] wait_r;

  logic                 slot_ok;
  logic [SLOT_W-1:0]    wr_idx;
  logic                 eligible;
  logic                 better;

  assign slot_ok = (32'(slot_q) < 32'(SLOTS));
  assign wr_idx  = SLOT_W'(slot_q);
  assign rd_addr = cmd.fetch ? best_slot : scan_idx;
  assign status.scan_last = (scan_idx == LAST_IDX);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      slot_q  <= slot;
      arr_q   <= TIME_BITS'(arrival);
      burst_q <= TIME_BITS'(burst);
      prio_q  <= priority_req;
    end
  end

  // Table memories: one write port shared by loads and the run step, one
  // registered read port shared by the scan and the fetch of the winner.
  always_ff @(posedge clk) begin
    if (cmd.load && slot_ok) begin
      arr_mem[wr_idx]   <= arr_q;
      burst_mem[wr_idx] <= burst_q;
      prio_mem[wr_idx]  <= prio_q;
    end
    if (cmd.load && slot_ok) begin
      rem_mem[wr_idx] <= burst_q;
    end else if (cmd.run && found) begin
      rem_mem[best_slot] <= rem_rd - 1'b1;
    end
    arr_rd   <= arr_mem[rd_addr];
    burst_rd <= burst_mem[rd_addr];
    rem_rd   <= rem_mem[rd_addr];
    prio_rd  <= prio_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      loaded   <= '0;
      finished <= '0;
    end else if (cmd.clear) begin
      loaded   <= '0;
      finished <= '0;
    end else if (cmd.load && slot_ok) begin
      loaded[wr_idx]   <= 1'b1;
      finished[wr_idx] <= (burst_q == '0);
    end else if (cmd.run && found && (rem_rd == TIME_BITS'(1))) begin
      finished[best_slot] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      time_cnt <= '0;
    end else if (cmd.clear) begin
      time_cnt <= '0;
    end else if (cmd.fetch && (time_cnt != TIME_MAX)) begin
      time_cnt <= time_cnt + 1'b1;
    end
  end

  // Scan: one slot address issued per cycle, evaluated in the cycle after it is issued.
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx <= '0;
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= cmd.scan;
      if (cmd.capture) begin
        scan_idx <= '0;
      end else if (cmd.scan && !status.scan_last) begin
        scan_idx <= scan_idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_q <= scan_idx;
  end

  assign eligible = rd_valid && loaded[idx_q] && !finished[idx_q] && (arr_rd <= time_cnt);
  assign better   = !found || (prio_rd > best_prio) ||
                    ((prio_rd == best_prio) && (arr_rd < best_arr));

  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (cmd.capture) begin
      found <= 1'b0;
    end else if (eligible && better) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      best_slot <= '0;
    end else if (eligible && better) begin
      best_slot <= idx_q;
      best_prio <= prio_rd;
      best_arr  <= arr_rd;
    end
  end

  // Run step and completion statistics. Time has already advanced when the
  // run step executes, so the counter holds the completion time.
  always_ff @(posedge clk) begin
    if (rst) begin
      ran_r       <= 1'b0;
      completed_r <= 1'b0;
    end else if (cmd.capture) begin
      ran_r       <= 1'b0;
      completed_r <= 1'b0;
    end else if (cmd.run && found) begin
      ran_r       <= 1'b1;
      completed_r <= (rem_rd == TIME_BITS'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      ctime_r <= '0;
      tat_r   <= '0;
      wait_r  <= '0;
    end else if (cmd.run && found && (rem_rd == TIME_BITS'(1))) begin
      ctime_r <= time_cnt;
      tat_r   <= time_cnt - arr_rd;
      burst_r <= burst_rd;
    end else if (cmd.finish && completed_r) begin
      wait_r <= (tat_r >= burst_r) ? (tat_r - burst_r) : '0;
    end
  end

  assign ran             = ran_r;
  assign ran_slot        = ran_r ? SIW'(best_slot) : '0;
  assign completed       = completed_r;
  assign completion_time = ctime_r;
  assign turnaround      = tat_r;
  assign waiting         = wait_r;
  assign all_done        = (|loaded) && !(|(loaded & ~finished));
  assign time_now        = time_cnt;

endmodule

// ----- hdl/preemptive_priority_scheduler.sv -----
// Preemptive priority scheduler over a table of SLOTS task slots.
// A request is issued by raising start with operation and its payload while
// busy is low; it is taken at that clock edge. Load writes one slot with an
// arrival time, a burst length and a priority. Tick picks the arrived,
// unfinished task of highest priority (ties to the earlier arrival, then to
// the lower slot), runs it for one tick and advances time, which saturates.
// Clear empties the table and sets time back to zero.
// Every request yields exactly one result, shown for a single cycle with
// done high. The receiver cannot hold a result off; it must take it then.
// A tick runs the selection scan, which reads one slot per cycle through the
// registered read port of the task table and compares it against the best
// candidate so far. busy stays high until the done cycle has passed, so one
// request is in flight at a time.
// A synchronous reset empties the table, zeroes time and returns the block
// to idle. Table contents are left as they are; only loaded slots take part.
module preemptive_priority_scheduler #(
  parameter int SLOTS     = 8,
  parameter int TIME_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [pps_pkg::OP_W-1:0]          operation,
  input  logic [pps_pkg::SLOT_IN_W-1:0]     slot,
  input  logic [pps_pkg::IN_TIME_W-1:0]     arrival,
  input  logic [pps_pkg::IN_TIME_W-1:0]     burst,
  input  logic [pps_pkg::PRIO_W-1:0]        priority_req,
  output logic                              done,
  output logic                              ran,
  output logic [pps_pkg::SLOT_IN_W-1:0]     ran_slot,
  output logic                              completed,
  output logic [TIME_BITS-1:0]              completion_time,
  output logic [TIME_BITS-1:0]              turnaround,
  output logic [TIME_BITS-1:0]              waiting,
  output logic                              all_done,
  output logic [TIME_BITS-1:0]              time_now
);

  // Commands and status between the controller and the datapath.
  pps_pkg::ctl_cmd_t    cmd;
  pps_pkg::ctl_status_t status;

  // The controller sequences each request: load and clear take a single
  // working state, a tick walks scan, settle, fetch, run and finish.
  pps_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .operation (operation),
    .status    (status),
    .cmd       (cmd),
    .busy      (busy),
    .done      (done)
  );

  // The datapath holds the task table, the time counter, the best-candidate
  // registers of the scan and the result registers.
  pps_datapath #(
    .SLOTS     (SLOTS),
    .TIME_BITS (TIME_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .slot            (slot),
    .arrival         (arrival),
    .burst           (burst),
    .priority_req    (priority_req),
    .ran             (ran),
    .ran_slot        (ran_slot),
    .completed       (completed),
    .completion_time (completion_time),
    .turnaround      (turnaround),
    .waiting         (waiting),
    .all_done        (all_done),
    .time_now        (time_now)
  );

endmodule

// ----- tb/sv/tb_top.sv -----
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS     = 8;
  localparam int TIME_BITS = 16;
  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

  // The block defines only three operation codes. The fourth is legal on the
  // port and must leave every piece of state alone.
  localparam logic [pps_pkg::OP_W-1:0] OP_NOP = 2'd3;

  // Random requests after the directed part. Idle gaps stop for the last
  // TAIL_REQS of them.
  localparam int RANDOM_REQS = 1250;
  localparam int TAIL_REQS   = 150;

  // One request as the driver presents it. The two trailing bits steer the
  // driver: hold makes it wait until every outstanding result has arrived,
  // and may_pause allows a random idle gap in front of the request.
  typedef struct packed {
    logic [pps_pkg::OP_W-1:0]      op;
    logic [pps_pkg::SLOT_IN_W-1:0] slot;
    logic [pps_pkg::IN_TIME_W-1:0] arrival;
    logic [pps_pkg::IN_TIME_W-1:0] burst;
    logic [pps_pkg::PRIO_W-1:0]    prio;
    logic                          hold;
    logic                          may_pause;
  } sched_req_t;

  // One result as the block reports it.
  typedef struct packed {
    logic                          ran;
    logic [pps_pkg::SLOT_IN_W-1:0] ran_slot;
    logic                          completed;
    logic [TIME_BITS-1:0]          completion_time;
    logic [TIME_BITS-1:0]          turnaround;
    logic [TIME_BITS-1:0]          waiting;
    logic                          all_done;
    logic [TIME_BITS-1:0]          time_now;
  } sched_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  sched_req_t cur_req = '0;

  logic                          busy;
  logic                          done;
  logic                          ran;
  logic [pps_pkg::SLOT_IN_W-1:0] ran_slot;
  logic                          completed;
  logic [TIME_BITS-1:0]          completion_time;
  logic [TIME_BITS-1:0]          turnaround;
  logic [TIME_BITS-1:0]          waiting;
  logic                          all_done;
  logic [TIME_BITS-1:0]          time_now;

  // Requests waiting to be driven, and results the scheduler owes us.
  sched_req_t    request_q[$];
  sched_result_t sched_outcomes_q[$];

  int  total_reqs = 0;
  int  accepted_reqs = 0;
  int  mismatches = 0;
  int  gap_left = 0;
  logic taken = 1'b0;

  // Shadow copy of the task table and the time counter. The per-slot
  // stores are left unknown; they are only read for loaded slots.
  logic [pps_pkg::IN_TIME_W-1:0] tab_arrival  [SLOTS];
  logic [pps_pkg::IN_TIME_W-1:0] tab_burst    [SLOTS];
  logic [pps_pkg::IN_TIME_W-1:0] tab_left     [SLOTS];
  logic [pps_pkg::PRIO_W-1:0]    tab_prio     [SLOTS];
  bit                            tab_loaded   [SLOTS];
  bit                            tab_finished [SLOTS];
  logic [TIME_BITS-1:0]          sched_time = '0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  preemptive_priority_scheduler #(
    .SLOTS(SLOTS),
    .TIME_BITS(TIME_BITS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .operation(cur_req.op),
    .slot(cur_req.slot),
    .arrival(cur_req.arrival),
    .burst(cur_req.burst),
    .priority_req(cur_req.prio),
    .done(done),
    .ran(ran),
    .ran_slot(ran_slot),
    .completed(completed),
    .completion_time(completion_time),
    .turnaround(turnaround),
    .waiting(waiting),
    .all_done(all_done),
    .time_now(time_now)
  );

  // Applies one accepted request to the shadow table and returns the result
  // the block must report for it.
  function automatic sched_result_t predict_schedule(sched_req_t r);
    sched_result_t res;
    bit found;
    bit any_loaded;
    bit all_finished;
    int best;
    int i;
    logic [TIME_BITS-1:0] tat;
    res = '0;
    found = 1'b0;
    best = 0;
    case (r.op)
      pps_pkg::OP_LOAD: begin
        tab_arrival[r.slot] = r.arrival;
        tab_burst[r.slot] = r.burst;
        tab_left[r.slot] = r.burst;
        tab_prio[r.slot] = r.prio;
        tab_loaded[r.slot] = 1'b1;
        // A task with no work counts as finished the moment it is loaded.
        tab_finished[r.slot] = (r.burst == '0);
      end
      pps_pkg::OP_TICK: begin
        // Pick the arrived, unfinished task with the largest priority. On a
        // tie the earlier arrival wins; on a second tie the scan order keeps
        // the lower slot because only a strictly better candidate replaces it.
        for (i = 0; i < SLOTS; i++) begin
          if (tab_loaded[i] && !tab_finished[i] && tab_arrival[i] <= sched_time) begin
            if (!found || tab_prio[i] > tab_prio[best] ||
                (tab_prio[i] == tab_prio[best] && tab_arrival[i] < tab_arrival[best])) begin
              best = i;
              found = 1'b1;
            end
          end
        end
        // Time moves even on an idle tick, but sticks at its maximum.
        if (sched_time != TIME_MAX) sched_time = sched_time + 1'b1;
        if (found) begin
          res.ran = 1'b1;
          res.ran_slot = pps_pkg::SLOT_IN_W'(best);
          tab_left[best] = tab_left[best] - 1'b1;
          if (tab_left[best] == '0) begin
            tab_finished[best] = 1'b1;
            tat = sched_time - tab_arrival[best];
            res.completed = 1'b1;
            res.completion_time = sched_time;
            res.turnaround = tat;
            // Once time has saturated, turnaround can fall short of the burst;
            // the waiting time is then reported as zero.
            res.waiting = (tat >= tab_burst[best]) ? tat - tab_burst[best] : '0;
          end
        end
      end
      pps_pkg::OP_CLEAR: begin
        for (i = 0; i < SLOTS; i++) begin
          tab_loaded[i] = 1'b0;
          tab_finished[i] = 1'b0;
        end
        sched_time = '0;
      end
      default: begin
      end
    endcase
    any_loaded = 1'b0;
    all_finished = 1'b1;
    for (i = 0; i < SLOTS; i++) begin
      if (tab_loaded[i]) begin
        any_loaded = 1'b1;
        if (!tab_finished[i]) all_finished = 1'b0;
      end
    end
    res.all_done = any_loaded && all_finished;
    res.time_now = sched_time;
    return res;
  endfunction

  function automatic void queue_request(logic [pps_pkg::OP_W-1:0] op,
                                        logic [pps_pkg::SLOT_IN_W-1:0] s,
                                        logic [pps_pkg::IN_TIME_W-1:0] a,
                                        logic [pps_pkg::IN_TIME_W-1:0] b,
                                        logic [pps_pkg::PRIO_W-1:0] p,
                                        logic hold, logic pause);
    sched_req_t r;
    r.op = op;
    r.slot = s;
    r.arrival = a;
    r.burst = b;
    r.prio = p;
    r.hold = hold;
    r.may_pause = pause;
    request_q.push_back(r);
    total_reqs++;
  endfunction

  function automatic void check_field(string what, logic [TIME_BITS-1:0] want,
                                      logic [TIME_BITS-1:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    end
  endfunction

  // Driver. Inputs move only at the falling edge. A new request is put up
  // once the previous one was taken at the last rising edge, or when start
  // is low. While the block is busy, start and the payload simply stay put.
  // Each pass makes at most one assignment to start.
  always @(negedge clk) begin
    logic drive_next;
    drive_next = 1'b0;
    if (rst) begin
      start <= 1'b0;
    end else if (!start || taken) begin
      // Right after an accepted request, sometimes open an idle gap before
      // the next one.
      if (start && request_q.size() > 0 && request_q[0].may_pause &&
          $urandom_range(2, 0) == 0)
        gap_left = $urandom_range(3, 1);
      if (gap_left > 0) begin
        gap_left--;
      end else if (request_q.size() > 0 &&
                   !(request_q[0].hold && sched_outcomes_q.size() > 0)) begin
        // A held request waits until the scheduler has nothing outstanding.
        cur_req <= request_q.pop_front();
        drive_next = 1'b1;
      end
      start <= drive_next;
    end
  end

  // Monitor. A request is taken at a rising edge with start high and busy
  // low; its expected result is computed right then. Every done strobe is
  // matched against the oldest expected result.
  always @(posedge clk) begin
    sched_result_t want;
    if (rst) begin
      taken <= 1'b0;
    end else begin
      taken <= start && !busy;
      if (start && !busy) begin
        sched_outcomes_q.push_back(predict_schedule(cur_req));
        accepted_reqs++;
      end
      if (done === 1'b1) begin
        if (sched_outcomes_q.size() == 0) begin
          mismatches++;
          $display("%0t ns: unexpected result, expected none, actual ran=%0b slot=%0d",
                   $time, ran, ran_slot);
        end else begin
          want = sched_outcomes_q.pop_front();
          check_field("ran", TIME_BITS'(want.ran), TIME_BITS'(ran));
          check_field("ran_slot", TIME_BITS'(want.ran_slot), TIME_BITS'(ran_slot));
          check_field("completed", TIME_BITS'(want.completed), TIME_BITS'(completed));
          check_field("completion_time", want.completion_time, completion_time);
          check_field("turnaround", want.turnaround, turnaround);
          check_field("waiting", want.waiting, waiting);
          check_field("all_done", TIME_BITS'(want.all_done), TIME_BITS'(all_done));
          check_field("time_now", want.time_now, time_now);
        end
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    int i;
    int n_random;
    int ticks;
    int work;
    int latest;
    bit pause;
    bit ties;
    logic [pps_pkg::IN_TIME_W-1:0] a;
    logic [pps_pkg::IN_TIME_W-1:0] b;
    logic [pps_pkg::PRIO_W-1:0] p;

    // Directed part. An idle tick on an empty table, the unused operation,
    // then a set of tasks that exercises both tie-break rules, the lowest
    // priority and a task that has no work at all.
    queue_request(pps_pkg::OP_TICK, '0, '0, '0, '0, 1'b0, 1'b1);
    queue_request(OP_NOP, '1, '1, '1, '1, 1'b0, 1'b1);
    queue_request(pps_pkg::OP_LOAD, 3'd0, 16'd0, 16'd2, 8'd255, 1'b0, 1'b1);
    queue_request(pps_pkg::OP_LOAD, 3'd4, 16'd0, 16'd1, 8'd255, 1'b0, 1'b1);
    queue_request(pps_pkg::OP_LOAD, 3'd2, 16'd1, 16'd1, 8'd255, 1'b0, 1'b1);
    queue_request(pps_pkg::OP_LOAD, 3'd7, 16'd0, 16'd1, 8'd0, 1'b0, 1'b1);
    queue_request(pps_pkg::OP_LOAD, 3'd3, 16'd0, 16'd0, 8'd100, 1'b0, 1'b1);
    repeat (6) queue_request(pps_pkg::OP_TICK, '0, '0, '0, '0, 1'b0, 1'b1);
    // Replace a task while it is part way through its work.
    queue_request(pps_pkg::OP_LOAD, 3'd5, 16'd0, 16'd3, 8'd10, 1'b0, 1'b1);
    queue_request(pps_pkg::OP_TICK, '0, '0, '0, '0, 1'b0, 1'b1);
    queue_request(pps_pkg::OP_LOAD, 3'd5, 16'd2, 16'd1, 8'd20, 1'b0, 1'b1);
    repeat (2) queue_request(pps_pkg::OP_TICK, '0, '0, '0, '0, 1'b0, 1'b1);
    // All-ones fields: a task that never arrives next to one that runs.
    queue_request(pps_pkg::OP_CLEAR, '0, '0, '0, '0, 1'b1, 1'b1);
    queue_request(pps_pkg::OP_LOAD, 3'd6, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b0, 1'b1);
    queue_request(pps_pkg::OP_LOAD, 3'd1, 16'd0, 16'd1, 8'd1, 1'b0, 1'b1);
    repeat (2) queue_request(pps_pkg::OP_TICK, '0, '0, '0, '0, 1'b0, 1'b1);

    // Random part, built from scenarios: clear, load a handful of short
    // tasks, then tick until they should all be done. Noise is mixed into
    // the tick stream: unused operations, loads with fully random fields,
    // reloads of a running table and clears in mid-run. Some scenarios run
    // without gaps, and the final stretch has none at all.
    n_random = 0;
    while (n_random < RANDOM_REQS) begin
      pause = (n_random < RANDOM_REQS - TAIL_REQS) && ($urandom_range(3, 0) != 0);
      queue_request(pps_pkg::OP_CLEAR, pps_pkg::SLOT_IN_W'($urandom),
                    pps_pkg::IN_TIME_W'($urandom), pps_pkg::IN_TIME_W'($urandom),
                    pps_pkg::PRIO_W'($urandom),
                    (n_random < RANDOM_REQS - TAIL_REQS) && ($urandom_range(5, 0) == 0),
                    pause);
      n_random++;
      // Half the scenarios draw priorities from a tiny set to force ties.
      ties = 1'($urandom_range(1, 0));
      work = 0;
      latest = 0;
      repeat ($urandom_range(8, 1)) begin
        a = pps_pkg::IN_TIME_W'($urandom_range(12, 0));
        b = pps_pkg::IN_TIME_W'($urandom_range(6, 1));
        case ($urandom_range(15, 0))
          0: b = '0;
          1: b = pps_pkg::IN_TIME_W'($urandom_range(40, 7));
          default: begin
          end
        endcase
        p = ties ? pps_pkg::PRIO_W'($urandom_range(2, 1)) : pps_pkg::PRIO_W'($urandom);
        queue_request(pps_pkg::OP_LOAD, pps_pkg::SLOT_IN_W'($urandom), a, b, p, 1'b0, pause);
        n_random++;
        work += int'(b);
        if (int'(a) > latest) latest = int'(a);
      end
      ticks = work + latest + int'($urandom_range(3, 0));
      if (ticks > 80) ticks = 80;
      for (i = 0; i < ticks; i++) begin
        case ($urandom_range(39, 0))
          0: queue_request(OP_NOP, pps_pkg::SLOT_IN_W'($urandom),
                           pps_pkg::IN_TIME_W'($urandom), pps_pkg::IN_TIME_W'($urandom),
                           pps_pkg::PRIO_W'($urandom), 1'b0, pause);
          1: begin
            queue_request(pps_pkg::OP_LOAD, pps_pkg::SLOT_IN_W'($urandom),
                          pps_pkg::IN_TIME_W'($urandom), pps_pkg::IN_TIME_W'($urandom),
                          pps_pkg::PRIO_W'($urandom), 1'b0, pause);
            n_random++;
          end
          2: begin
            queue_request(pps_pkg::OP_LOAD, pps_pkg::SLOT_IN_W'($urandom),
                          pps_pkg::IN_TIME_W'($urandom_range(latest + 4, 0)),
                          pps_pkg::IN_TIME_W'($urandom_range(4, 1)),
                          pps_pkg::PRIO_W'($urandom), 1'b0, pause);
            n_random++;
          end
          3: begin
            queue_request(pps_pkg::OP_CLEAR, '0, '0, '0, '0, 1'b0, pause);
            n_random++;
          end
          default: begin
            queue_request(pps_pkg::OP_TICK, pps_pkg::SLOT_IN_W'($urandom),
                          pps_pkg::IN_TIME_W'($urandom), pps_pkg::IN_TIME_W'($urandom),
                          pps_pkg::PRIO_W'($urandom), 1'b0, pause);
            n_random++;
          end
        endcase
      end
    end

    // Hold reset, then release it at a falling edge.
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // Wait until every request was taken and every result came back, then
    // give the block a little longer than a tick to show any stray strobe.
    while (accepted_reqs < total_reqs || sched_outcomes_q.size() > 0) @(negedge clk);
    repeat (SLOTS + 8) @(negedge clk);

    if (sched_outcomes_q.size() > 0)
      $display("%0t ns: %0d results never arrived", $time, sched_outcomes_q.size());
    if (mismatches == 0 && sched_outcomes_q.size() == 0) begin
      $display("preemptive_priority_scheduler regression: pass");
    end else begin
      $display("preemptive_priority_scheduler regression: fail");
    end
    $finish;
  end

  // Watchdog, several times the length of the slowest correct run.
  initial begin
    #1_000_000;
    $display("preemptive_priority_scheduler regression: fail");
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/pps_pkg.sv
hdl/pps_ctrl.sv
hdl/pps_datapath.sv
hdl/preemptive_priority_scheduler.sv
tb/sv/tb_top.sv
